// ===== rtl/modular_exponentiation_defines.svh =====
// Assertion macros shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MX_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp assertion failed");

`endif

// ===== rtl/modexp_pkg.sv =====
// Package with the shared types and constants of the modular exponentiation block.
`default_nettype none
package modexp_pkg;
    localparam int EXP_BITS_DEF = 8;
    localparam int EXP_REG_W = 8;
    localparam int MOD_W = 16;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = MOD_W / DIV_STEPS;
    localparam int UNIT_STAGES = DIV_STAGES + 1;
    localparam logic [MOD_W-1:0] MODULUS_RST = 16'd59989;
    localparam logic [EXP_REG_W-1:0] EXPONENT_RST = 8'd41;
    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    typedef struct packed {
        logic             vld;
        logic [MOD_W-1:0] acc;
        logic [MOD_W-1:0] br;
        logic [MOD_W:0]   rem;
        logic [MOD_W-1:0] quo;
    } t_stage;
endpackage
`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Pipelined square-and-multiply modular exponentiation, top level.
// Usage:
//   Bases enter on the slave stream (i_s_axis_*); each request yields one
//   result, base ** exponent mod modulus, on the master stream (o_m_axis_*).
//   Modulus (index 0) and exponent (index 1) are written on the plain write
//   port, which the user must do only while no request is in flight; the
//   block does not enforce this. They reset to 59989 and 41. The pipeline
//   first reduces the base, then runs one square and one multiply (by the
//   base or by one) for each exponent bit, msb first. Each modular product
//   takes one multiply stage and four division stages that retire four
//   remainder bits each. A new base is accepted in every cycle unless the
//   pipeline is full and the receiver stalls; throughput is one per cycle.
//   When the receiver stalls, results stay in the pipeline and empty
//   stages still fill, so input is refused only once every stage is full.
//   Reset empties the pipeline and restores both registers.
`default_nettype none
`include "modular_exponentiation_defines.svh"
module modular_exponentiation #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [15:0] base
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,  // [15:0] power
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    localparam int NS = (2 * EXP_BITS + 1) * modexp_pkg::UNIT_STAGES;
    localparam int MW = modexp_pkg::MOD_W;

    logic [MW-1:0] r_modulus;
    logic [modexp_pkg::EXP_REG_W-1:0] r_exponent;
    modexp_pkg::t_stage r_st [NS];
    logic [NS-1:0] w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= modexp_pkg::MODULUS_RST;
            r_exponent <= modexp_pkg::EXPONENT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                modexp_pkg::CFG_MODULUS: r_modulus <= i_cfg_data;
                modexp_pkg::CFG_EXPONENT: r_exponent <= i_cfg_data[modexp_pkg::EXP_REG_W-1:0];
                default: r_modulus <= r_modulus;
            endcase
        end
    end

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            localparam int UNIT = s / modexp_pkg::UNIT_STAGES;
            localparam int PHASE = s % modexp_pkg::UNIT_STAGES;
            localparam int KSTEP = (UNIT > 0) ? UNIT - 1 : 0;
            localparam int EIDX = EXP_BITS - 1 - KSTEP / 2;
            modexp_pkg::t_stage w_prev;
            modexp_pkg::t_stage n_st;

            if (s == 0) begin : g_src
                always_comb begin
                    w_prev = '0;
                    w_prev.vld = i_s_axis_tvalid;
                    w_prev.br = i_s_axis_tdata;
                end
            end else begin : g_src
                assign w_prev = r_st[s-1];
            end

            if (s == NS - 1) begin : g_adv
                assign w_adv[s] = ~r_st[s].vld | i_m_axis_tready;
            end else begin : g_adv
                assign w_adv[s] = ~r_st[s].vld | w_adv[s+1];
            end

            if (PHASE == 0) begin : g_mul
                logic [MW-1:0] w_x;
                logic [MW-1:0] w_y;
                logic [2*MW-1:0] w_prod;
                logic w_ebit;
                if (UNIT > 0 && KSTEP % 2 == 1 && EIDX < modexp_pkg::EXP_REG_W) begin : g_e
                    assign w_ebit = r_exponent[EIDX % modexp_pkg::EXP_REG_W];
                end else begin : g_e
                    assign w_ebit = 1'b0;
                end
                always_comb begin
                    if (UNIT == 0) begin
                        w_x = w_prev.br;
                        w_y = MW'(1);
                    end else if (KSTEP % 2 == 0) begin
                        w_x = w_prev.acc;
                        w_y = w_prev.acc;
                    end else begin
                        w_x = w_prev.acc;
                        w_y = w_ebit ? w_prev.br : MW'(1);
                    end
                    w_prod = w_x * w_y;
                    n_st = w_prev;
                    n_st.rem = {1'b0, w_prod[2*MW-1:MW]};
                    n_st.quo = w_prod[MW-1:0];
                end
            end else begin : g_div
                always_comb begin
                    n_st = w_prev;
                    for (int k = 0; k < modexp_pkg::DIV_STEPS; k++) begin
                        n_st.rem = {n_st.rem[MW-1:0], n_st.quo[MW-1]};
                        n_st.quo = {n_st.quo[MW-2:0], 1'b0};
                        if (n_st.rem >= {1'b0, r_modulus}) begin
                            n_st.rem = n_st.rem - {1'b0, r_modulus};
                        end
                    end
                    if (PHASE == modexp_pkg::DIV_STAGES) begin
                        if (UNIT == 0) begin
                            n_st.br = n_st.rem[MW-1:0];
                            n_st.acc = MW'(1);
                        end else if (s == NS - 1 && r_modulus == '0) begin
                            n_st.acc = '0;
                        end else begin
                            n_st.acc = n_st.rem[MW-1:0];
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_st[s].vld <= 1'b0;
                end else if (w_adv[s]) begin
                    r_st[s] <= n_st;
                end
            end
        end
    endgenerate

    assign o_s_axis_tready = w_adv[0];
    assign o_m_axis_tvalid = r_st[NS-1].vld;
    assign o_m_axis_tdata = r_st[NS-1].acc;

    `MX_ASSERT_SAME(a_zero_mod, i_clk, i_rst_n, o_m_axis_tvalid && r_modulus == '0,
        o_m_axis_tdata == '0)
    `MX_ASSERT_SAME(a_reduced, i_clk, i_rst_n, o_m_axis_tvalid && r_modulus != '0,
        o_m_axis_tdata < r_modulus)
    `MX_ASSERT_SAME(a_full_refuse, i_clk, i_rst_n, !o_s_axis_tready,
        r_st[0].vld && o_m_axis_tvalid && !i_m_axis_tready)
    `MX_ASSERT_NEXT(a_fill, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready,
        r_st[0].vld)
endmodule
`default_nettype wire

// ===== tb/modexp_checker.sv =====
// Checker that predicts modular exponentiation results and compares them with the block's output.
`timescale 1ns / 1ps
module modexp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [15:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);
    logic [modexp_pkg::MOD_W-1:0]     modulus_q;
    logic [modexp_pkg::EXP_REG_W-1:0] exponent_q;
    logic [15:0]                      power_queue[$];

    function automatic logic [15:0] predict_power(input logic [15:0] base,
                                                  input logic [15:0] m,
                                                  input logic [7:0] e);
        logic [31:0] acc;
        if (m == 0) return 16'd0;
        acc = 32'd1 % m;
        for (int i = modexp_pkg::EXP_BITS_DEF - 1; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (i < 8 && e[i]) acc = (acc * base) % m;
        end
        return acc[15:0];
    endfunction

    assign o_pending = power_queue.size();

    always @(posedge i_clk) begin
        logic [15:0] expected;
        if (!i_rst_n) begin
            modulus_q  <= modexp_pkg::MODULUS_RST;
            exponent_q <= modexp_pkg::EXPONENT_RST;
            power_queue.delete();
            o_errors   <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                power_queue.push_back(predict_power(i_s_tdata, modulus_q, exponent_q));
            if (i_m_tvalid && i_m_tready) begin
                if (power_queue.size() == 0) begin
                    $error("power: result with no request pending, actual %0d", i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    expected = power_queue.pop_front();
                    if (expected !== i_m_tdata) begin
                        $error("power: expected %0d actual %0d", expected, i_m_tdata);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == modexp_pkg::CFG_MODULUS) modulus_q <= i_cfg_data;
                else exponent_q <= i_cfg_data[7:0];
            end
        end
    end
endmodule

// ===== tb/tb_modular_exponentiation.sv =====
// Testbench top that drives bases and register settings into the modular exponentiation block.
`timescale 1ns / 1ps
module tb_modular_exponentiation;
    localparam int LATENCY = 85;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = modexp_pkg::CFG_MODULUS;
    logic [15:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          long_stall = 1'b0;

    always #4 i_clk = ~i_clk;

    modular_exponentiation DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    modexp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    task automatic send_base(input logic [15:0] base);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= base;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] m, input logic [7:0] e);
        drain_results();
        write_reg(modexp_pkg::CFG_MODULUS, m);
        write_reg(modexp_pkg::CFG_EXPONENT, {8'h00, e});
    endtask

    // Receiver: random stalls per result, plus one long hold-off while the sender streams.
    always begin
        int wait_n;
        if (long_stall) begin
            m_tready <= 1'b0;
            repeat (1200) @(posedge i_clk);
            long_stall = 1'b0;
            m_tready <= 1'b1;
        end else begin
            wait_n = $urandom_range(0, 12);
            if (wait_n != 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
        do @(posedge i_clk); while (!(m_tvalid && m_tready) && !long_stall);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [15:0] mods[6];
        logic [7:0]  exps[6];
        mods = '{16'd59989, 16'd65535, 16'd2, 16'd1, 16'd0, 16'd251};
        exps = '{8'd41, 8'd255, 8'd0, 8'd128, 8'd1, 8'd170};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset values first, with extremes of base; then extreme modulus and exponent settings.
        send_base(16'd0);
        send_base(16'd1);
        send_base(16'hFFFF);
        send_base(16'd59989);
        send_base(16'hAAAA);
        send_base(16'h5555);
        for (int k = 1; k < 6; k++) begin
            set_regs(mods[k], exps[k]);
            send_base(16'd0);
            send_base(16'hFFFF);
            send_base(16'd2);
        end
        for (int phase = 0; phase < 5; phase++) begin
            set_regs(16'($urandom_range(2, 65535)), 8'($urandom_range(0, 255)));
            if (phase == 2) long_stall = 1'b1;
            repeat (200) send_base(16'($urandom_range(0, 65535)));
        end
        set_regs(16'd65535, 8'd255);
        repeat (20) send_base(16'($urandom_range(0, 65535)));
        drain_results();
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modular_exponentiation.sv
tb/modexp_checker.sv
tb/tb_modular_exponentiation.sv
